// ===== design/asc85_pkg.sv =====
// ----------------------------------------------------------------------------
// asc85_pkg
// Types, character constants and helper functions shared by the decoder.
// ----------------------------------------------------------------------------
package asc85_pkg;

    typedef enum logic [2:0] {
        MODE_OUT   = 3'd0,
        MODE_LT    = 3'd1,
        MODE_IN    = 3'd2,
        MODE_TILDE = 3'd3,
        MODE_SKIP  = 3'd4,
        MODE_HALT  = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        STATUS_DATA     = 3'd0,
        STATUS_BAD_CHAR = 3'd1,
        STATUS_Z_MID    = 3'd2,
        STATUS_TILDE    = 3'd3,
        STATUS_END_IN   = 3'd4
    } t_status;

    // results of one item; data[0] goes out first
    typedef struct packed {
        logic [2:0]      count;
        logic [3:0][7:0] data;
        t_status         status;
    } t_bundle;

    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_U     = 8'h75;
    localparam logic [7:0] CHAR_Z     = 8'h7A;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;

    localparam logic [2:0] GROUP_LAST = 3'd4;

    function automatic logic [31:0] weight85(input logic [2:0] idx);
        logic [31:0] w;
        case (idx)
            3'd0:    w = 32'd52200625;
            3'd1:    w = 32'd614125;
            3'd2:    w = 32'd7225;
            3'd3:    w = 32'd85;
            3'd4:    w = 32'd1;
            default: w = 32'd0;
        endcase
        return w;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h0A) || (c == 8'h0D) || (c == 8'h09) || (c == 8'h20) ||
               (c == 8'h00) || (c == 8'h0C) || (c == 8'h08) || (c == CHAR_DEL);
    endfunction

endpackage

// ===== design/ascii85_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// ascii85_stream_decoder_core
// ASCII85 stream decoder with byte pass-through outside encoded regions when preserve_outside is set.
// ----------------------------------------------------------------------------
// Input channel: one character byte or an end-of-input marker per transfer
// (i_in_valid / o_in_ready). Output channel: one byte with status and last
// per transfer (o_out_valid / i_out_ready); last marks the final result of
// an input item. An item gives zero to four results. Items are decoded from
// the input register; their results load into the result register when it
// is free. Throughput: one item per cycle while each item gives at most one
// result and the receiver is ready; a multi-result item holds the result
// register until all are sent, and one more item can wait in the input
// register. Receiver stall: results stay put; the result register and the
// input register fill, then o_in_ready drops. Items giving no result still
// pass. Reset (synchronous, active low) returns to the outside-region
// state and clears preserve_outside, which i_cfg_wr_en / i_cfg_wr_data
// write; the user must write it only while the block is idle, which the
// block does not enforce. After an error result the block drops all items.
// ----------------------------------------------------------------------------
module ascii85_stream_decoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_status,
    output logic       o_last
);

    logic               dec_valid;
    logic [7:0]         dec_byte;
    logic               dec_eoi;
    logic               advance;
    logic               buf_free;
    asc85_pkg::t_bundle bundle;

    asc85_in_reg u_in_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .i_advance      (advance),
        .o_valid        (dec_valid),
        .o_byte         (dec_byte),
        .o_eoi          (dec_eoi)
    );

    asc85_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (dec_valid),
        .i_byte        (dec_byte),
        .i_eoi         (dec_eoi),
        .i_buf_free    (buf_free),
        .o_advance     (advance),
        .o_bundle      (bundle)
    );

    asc85_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance && (bundle.count != 3'd0)),
        .i_bundle    (bundle),
        .o_free      (buf_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

// ===== design/asc85_in_reg.sv =====
// ----------------------------------------------------------------------------
// asc85_in_reg
// Input register: holds one accepted item until the decode stage takes it.
// ----------------------------------------------------------------------------
module asc85_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_eoi
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_eoi;
    logic       load;

    assign o_in_ready = !r_valid || i_advance;
    assign load       = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_in_byte;
            r_eoi  <= i_end_of_input;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_eoi   = r_eoi;

endmodule

// ===== design/asc85_decode.sv =====
// ----------------------------------------------------------------------------
// asc85_decode
// Region tracking, base-85 group accumulation and result forming.
// ----------------------------------------------------------------------------
module asc85_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    input  logic               i_eoi,
    input  logic               i_buf_free,
    output logic               o_advance,
    output asc85_pkg::t_bundle o_bundle
);

    asc85_pkg::t_mode r_mode, n_mode;
    logic [2:0]       r_count, n_count;
    logic [31:0]      r_group, n_group;
    logic             r_preserve;

    logic [7:0]  digit;
    logic [31:0] digit_ext;
    logic [31:0] sum_digit;
    logic [31:0] sum_round;
    logic [2:0]  count_dec;
    logic        is_digit;
    logic        is_ws;
    asc85_pkg::t_bundle bundle;

    assign digit     = i_byte - asc85_pkg::CHAR_BANG;
    assign digit_ext = {25'd0, digit[6:0]};
    assign sum_digit = r_group + digit_ext * asc85_pkg::weight85(r_count);
    assign count_dec = r_count - 3'd1;
    assign sum_round = r_group + asc85_pkg::weight85(count_dec);
    assign is_digit  = (i_byte >= asc85_pkg::CHAR_BANG) && (i_byte <= asc85_pkg::CHAR_U);
    assign is_ws     = asc85_pkg::is_space(i_byte);

    // next state
    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        n_group = r_group;
        case (r_mode)
            asc85_pkg::MODE_OUT: begin
                if (!i_eoi && i_byte == asc85_pkg::CHAR_LT) begin
                    n_mode = asc85_pkg::MODE_LT;
                end
            end
            asc85_pkg::MODE_LT: begin
                n_mode = asc85_pkg::MODE_OUT;
                if (!i_eoi && i_byte == asc85_pkg::CHAR_TILDE) begin
                    n_mode  = asc85_pkg::MODE_IN;
                    n_count = 3'd0;
                    n_group = 32'd0;
                end
            end
            asc85_pkg::MODE_IN: begin
                if (i_eoi) begin
                    n_mode = asc85_pkg::MODE_HALT;
                end else if (is_ws) begin
                    n_mode = asc85_pkg::MODE_IN;
                end else if (i_byte == asc85_pkg::CHAR_Z) begin
                    if (r_count != 3'd0) begin
                        n_mode = asc85_pkg::MODE_HALT;
                    end
                end else if (i_byte == asc85_pkg::CHAR_TILDE) begin
                    n_mode = asc85_pkg::MODE_TILDE;
                end else if (is_digit) begin
                    if (r_count == asc85_pkg::GROUP_LAST) begin
                        n_count = 3'd0;
                        n_group = 32'd0;
                    end else begin
                        n_count = r_count + 3'd1;
                        n_group = sum_digit;
                    end
                end else begin
                    n_mode = asc85_pkg::MODE_HALT;
                end
            end
            asc85_pkg::MODE_TILDE: begin
                if (i_eoi || i_byte != asc85_pkg::CHAR_GT) begin
                    n_mode = asc85_pkg::MODE_HALT;
                end else begin
                    n_mode  = asc85_pkg::MODE_SKIP;
                    n_count = 3'd0;
                    n_group = 32'd0;
                end
            end
            asc85_pkg::MODE_SKIP: begin
                n_mode = asc85_pkg::MODE_OUT;
            end
            default: begin
                n_mode = asc85_pkg::MODE_HALT;
            end
        endcase
    end

    // results
    always_comb begin
        bundle.count  = 3'd0;
        bundle.data   = '0;
        bundle.status = asc85_pkg::STATUS_DATA;
        case (r_mode)
            asc85_pkg::MODE_OUT: begin
                if (!i_eoi && i_byte != asc85_pkg::CHAR_LT && r_preserve) begin
                    bundle.count   = 3'd1;
                    bundle.data[0] = i_byte;
                end
            end
            asc85_pkg::MODE_LT: begin
                if (r_preserve) begin
                    if (i_eoi) begin
                        bundle.count   = 3'd1;
                        bundle.data[0] = asc85_pkg::CHAR_LT;
                    end else if (i_byte != asc85_pkg::CHAR_TILDE) begin
                        bundle.count   = 3'd2;
                        bundle.data[0] = asc85_pkg::CHAR_LT;
                        bundle.data[1] = i_byte;
                    end
                end
            end
            asc85_pkg::MODE_IN: begin
                if (i_eoi) begin
                    bundle.count  = 3'd1;
                    bundle.status = asc85_pkg::STATUS_END_IN;
                end else if (is_ws) begin
                    bundle.count = 3'd0;
                end else if (i_byte == asc85_pkg::CHAR_Z) begin
                    if (r_count != 3'd0) begin
                        bundle.count  = 3'd1;
                        bundle.status = asc85_pkg::STATUS_Z_MID;
                    end else begin
                        bundle.count = 3'd4;
                    end
                end else if (i_byte == asc85_pkg::CHAR_TILDE) begin
                    bundle.count = 3'd0;
                end else if (is_digit) begin
                    if (r_count == asc85_pkg::GROUP_LAST) begin
                        bundle.count   = 3'd4;
                        bundle.data[0] = sum_digit[31:24];
                        bundle.data[1] = sum_digit[23:16];
                        bundle.data[2] = sum_digit[15:8];
                        bundle.data[3] = sum_digit[7:0];
                    end
                end else begin
                    bundle.count  = 3'd1;
                    bundle.status = asc85_pkg::STATUS_BAD_CHAR;
                end
            end
            asc85_pkg::MODE_TILDE: begin
                if (i_eoi || i_byte != asc85_pkg::CHAR_GT) begin
                    bundle.count  = 3'd1;
                    bundle.status = asc85_pkg::STATUS_TILDE;
                end else if (r_count != 3'd0) begin
                    bundle.count   = count_dec;
                    bundle.data[0] = sum_round[31:24];
                    bundle.data[1] = sum_round[23:16];
                    bundle.data[2] = sum_round[15:8];
                    bundle.data[3] = sum_round[7:0];
                end
            end
            default: begin
                bundle.count = 3'd0;
            end
        endcase
    end

    assign o_advance = i_valid && (bundle.count == 3'd0 || i_buf_free);
    assign o_bundle  = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= asc85_pkg::MODE_OUT;
            r_count <= 3'd0;
            r_group <= 32'd0;
        end else if (o_advance) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_group <= n_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preserve <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_preserve <= i_cfg_wr_data;
        end
    end

endmodule

// ===== design/asc85_out_buf.sv =====
// ----------------------------------------------------------------------------
// asc85_out_buf
// Result register: holds the results of one item and sends them one a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module asc85_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  asc85_pkg::t_bundle i_bundle,
    output logic               o_free,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_out_byte,
    output logic [2:0]         o_status,
    output logic               o_last
);

    logic [2:0]          r_rem;
    logic [3:0][7:0]     r_data;
    asc85_pkg::t_status  r_status;
    logic                pop;

    assign pop    = (r_rem != 3'd0) && i_out_ready;
    assign o_free = (r_rem == 3'd0) || ((r_rem == 3'd1) && i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 3'd0;
        end else if (i_load) begin
            r_rem <= i_bundle.count;
        end else if (pop) begin
            r_rem <= r_rem - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data   <= i_bundle.data;
            r_status <= i_bundle.status;
        end else if (pop) begin
            r_data <= {8'd0, r_data[3:1]};
        end
    end

    assign o_out_valid = (r_rem != 3'd0);
    assign o_out_byte  = r_data[0];
    assign o_status    = r_status;
    assign o_last      = (r_rem == 3'd1);

endmodule

// ===== design/asc85_checker.sv =====
// ----------------------------------------------------------------------------
// asc85_checker
// Port-level checks on the decoder's output channel, bound to the top level.
// ----------------------------------------------------------------------------
module asc85_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic [2:0] o_status,
    input logic       o_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_status) && $stable(o_last))
        else $error("output result changed while stalled");

    // an error is a single result with a zero byte
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != asc85_pkg::STATUS_DATA |->
            o_last && o_out_byte == 8'd0)
        else $error("error result not last or byte not zero");

    // nothing follows an error
    a_err_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_status != asc85_pkg::STATUS_DATA |=>
            !o_out_valid)
        else $error("result after error");

    // the rest of an item follows without a gap
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=>
            o_out_valid && o_status == asc85_pkg::STATUS_DATA)
        else $error("gap inside multi-byte result");

endmodule

bind ascii85_stream_decoder_core asc85_checker u_asc85_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_byte  (o_out_byte),
    .o_status    (o_status),
    .o_last      (o_last)
);
